// ===== rtl/cgst_pkg.sv =====
`default_nettype none
package cgst_pkg;
   localparam int MaxStops = 16;
   localparam int IdxW = $clog2(MaxStops);
   localparam int CntW = $clog2(MaxStops + 1);

   localparam logic [1:0] OP_LOOKUP = 2'd0;
   localparam logic [1:0] OP_INSERT = 2'd1;
   localparam logic [1:0] OP_SCALE  = 2'd2;
   // spare code, request completes with no effect
   localparam logic [1:0] OP_NONE   = 2'd3;

   localparam logic [2:0] ST_OK    = 3'd0;
   localparam logic [2:0] ST_CLAMP = 3'd1;
   localparam logic [2:0] ST_FULL  = 3'd2;
   localparam logic [2:0] ST_EMPTY = 3'd3;
   localparam logic [2:0] ST_ZERO  = 3'd4;

   // request to the shared divider
   typedef struct packed {
      logic        start;
      logic [39:0] dividend;
      logic [15:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic        done;
      logic [39:0] quotient;
   } div_rsp_type;
endpackage
`default_nettype wire

// ===== rtl/cgst_div.sv =====
`default_nettype none
// restoring divider, one quotient bit per cycle
module cgst_div (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire cgst_pkg::div_req_type req,
   output cgst_pkg::div_rsp_type     rsp
);
   logic [39:0] quo_ff, quo_in;
   logic [15:0] rem_ff, rem_in;
   logic [15:0] dvs_ff, dvs_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [16:0] trial;
   logic [16:0] shifted;

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      shifted = {rem_ff, quo_ff[39]};
      trial   = shifted - {1'b0, dvs_ff};
      if (req.start) begin
         quo_in  = req.dividend;
         rem_in  = '0;
         dvs_in  = req.divisor;
         cnt_in  = 6'd40;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!trial[16]) begin
            rem_in = trial[15:0];
            quo_in = {quo_ff[38:0], 1'b1};
         end else begin
            rem_in = shifted[15:0];
            quo_in = {quo_ff[38:0], 1'b0};
         end
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign rsp.done     = done_ff;
   assign rsp.quotient = quo_ff;

   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(busy_ff)) else $error("divider done without work");
   a_no_start_busy: assert property (@(posedge clock) disable iff (reset)
      busy_ff && !req.start |=> busy_ff || done_ff) else $error("divider lost");
   a_count_pos: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> cnt_ff != 6'd0) else $error("divider count");
endmodule
`default_nettype wire

// ===== rtl/color_gradient_stop_table_top.sv =====
`default_nettype none
// Color stop table with lookup, insert and scale requests. A request is taken
// when start is high and busy is low; its one result appears for a single
// cycle with rsp_valid in the cycle that busy falls and cannot be stalled.
// Lookup and insert walk the stop table one entry a cycle, and lookup and
// scale use one shared 40-step restoring divider. A lookup makes three
// channel divisions (none when empty, clamped or exact), and scale makes one
// division per stop (none when empty or zero span or length).
module color_gradient_stop_table_top (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [1:0]  req_operation,
   input  wire logic [15:0] req_position,
   input  wire logic [7:0]  req_stop_red,
   input  wire logic [7:0]  req_stop_green,
   input  wire logic [7:0]  req_stop_blue,
   input  wire logic [15:0] req_new_length,
   output logic             rsp_valid,
   output logic [7:0]       rsp_mixed_red,
   output logic [7:0]       rsp_mixed_green,
   output logic [7:0]       rsp_mixed_blue,
   output logic [2:0]       rsp_status,
   output logic [15:0]      rsp_left_bound,
   output logic [15:0]      rsp_right_bound
);
   localparam int IW = cgst_pkg::IdxW;
   localparam int CW = cgst_pkg::CntW;

   typedef enum logic [3:0] {
      S_IDLE, S_SEARCH, S_SHIFT, S_MIX, S_MIXW, S_SCAN, S_SCW, S_DONE
   } state_type;

   state_type   state_ff;
   logic [15:0] pos_mem [cgst_pkg::MaxStops];
   logic [23:0] col_mem [cgst_pkg::MaxStops];
   logic [CW-1:0] count_ff;
   logic [1:0]  op_ff;
   logic [15:0] x_ff, len_ff;
   logic [23:0] newc_ff, cl_ff, cr_ff, res_ff;
   logic [CW-1:0] i_ff, n_ff;
   logic [15:0] wl_ff, wr_ff, span_ff, lastq_ff;
   logic [1:0]  ch_ff;
   logic [2:0]  st_ff;
   cgst_pkg::div_req_type dreq_ff;
   cgst_pkg::div_rsp_type drsp;
   logic [IW-1:0] i_idx, last_idx, n_idx;
   logic [15:0] pos_i;
   logic [23:0] col_i;
   logic [16:0] dsum;
   logic [39:0] num;
   logic [7:0]  cl_ch, cr_ch;
   logic [23:0] mul_l, mul_r;
   logic [31:0] mul_s;

   assign i_idx    = i_ff[IW-1:0];
   assign n_idx    = n_ff[IW-1:0];
   assign last_idx = IW'(count_ff - CW'(1));
   assign pos_i    = pos_mem[i_idx];
   assign col_i    = col_mem[i_idx];
   assign dsum     = {1'b0, wl_ff} + {1'b0, wr_ff};
   assign mul_s    = {16'd0, pos_i} * {16'd0, len_ff};

   // pick channel and build mix numerator
   always_comb begin
      case (ch_ff)
         2'd0:    begin cl_ch = cl_ff[23:16]; cr_ch = cr_ff[23:16]; end
         2'd1:    begin cl_ch = cl_ff[15:8];  cr_ch = cr_ff[15:8];  end
         default: begin cl_ch = cl_ff[7:0];   cr_ch = cr_ff[7:0];   end
      endcase
      mul_l = {16'd0, cl_ch} * {8'd0, wl_ff};
      mul_r = {16'd0, cr_ch} * {8'd0, wr_ff};
      num = {16'd0, mul_l} + {16'd0, mul_r} + {24'd0, dsum[16:1]};
   end

   cgst_div u_div (.clock(clock), .reset(reset), .req(dreq_ff), .rsp(drsp));

   // sequencer
   always_ff @(posedge clock) begin
      dreq_ff.start <= !reset && (state_ff == S_MIX
                                  || (state_ff == S_SCAN && i_ff != count_ff));
      rsp_valid     <= !reset && (state_ff == S_DONE);
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
      end else begin
         unique case (state_ff)
            S_IDLE: begin
               if (start) begin
                  op_ff   <= req_operation;
                  x_ff    <= req_position;
                  len_ff  <= req_new_length;
                  newc_ff <= {req_stop_red, req_stop_green, req_stop_blue};
                  res_ff  <= '0;
                  st_ff   <= cgst_pkg::ST_OK;
                  i_ff    <= '0;
                  n_ff    <= '0;
                  ch_ff   <= '0;
                  if (req_operation == cgst_pkg::OP_SCALE) begin
                     span_ff <= pos_mem[IW'(count_ff - CW'(1))] - pos_mem[0];
                     if (count_ff == '0) begin
                        st_ff <= cgst_pkg::ST_EMPTY; state_ff <= S_DONE;
                     end else if (pos_mem[IW'(count_ff - CW'(1))] == pos_mem[0]
                                  || req_new_length == '0) begin
                        st_ff <= cgst_pkg::ST_ZERO; state_ff <= S_DONE;
                     end else state_ff <= S_SCAN;
                  end else if (req_operation == cgst_pkg::OP_LOOKUP
                               || req_operation == cgst_pkg::OP_INSERT)
                     state_ff <= S_SEARCH;
                  else state_ff <= S_DONE;
               end
            end
            S_SEARCH: begin
               if (op_ff == cgst_pkg::OP_LOOKUP) begin
                  if (count_ff == '0) begin
                     st_ff <= cgst_pkg::ST_EMPTY; state_ff <= S_DONE;
                  end else if (x_ff < pos_mem[0]) begin
                     res_ff <= col_mem[0]; st_ff <= cgst_pkg::ST_CLAMP;
                     state_ff <= S_DONE;
                  end else if (x_ff > pos_mem[last_idx]) begin
                     res_ff <= col_mem[last_idx]; st_ff <= cgst_pkg::ST_CLAMP;
                     state_ff <= S_DONE;
                  end else if (pos_i == x_ff) begin
                     res_ff <= col_i; state_ff <= S_DONE;
                  end else if (pos_i > x_ff) begin
                     cl_ff <= col_mem[IW'(i_ff - CW'(1))];
                     cr_ff <= col_i;
                     wl_ff <= pos_i - x_ff;
                     wr_ff <= x_ff - pos_mem[IW'(i_ff - CW'(1))];
                     state_ff <= S_MIX;
                  end else i_ff <= i_ff + CW'(1);
               end else begin
                  if (i_ff < count_ff && pos_i == x_ff) begin
                     col_mem[i_idx] <= newc_ff; state_ff <= S_DONE;
                  end else if (i_ff < count_ff && !(pos_i > x_ff))
                     i_ff <= i_ff + CW'(1);
                  else if (count_ff == CW'(cgst_pkg::MaxStops)) begin
                     st_ff <= cgst_pkg::ST_FULL; state_ff <= S_DONE;
                  end else begin
                     n_ff <= count_ff; state_ff <= S_SHIFT;
                  end
               end
            end
            S_SHIFT: begin
               // move entries up one slot from the top down
               if (n_ff > i_ff) begin
                  pos_mem[n_idx] <= pos_mem[IW'(n_ff - CW'(1))];
                  col_mem[n_idx] <= col_mem[IW'(n_ff - CW'(1))];
                  n_ff <= n_ff - CW'(1);
               end else begin
                  pos_mem[i_idx] <= x_ff;
                  col_mem[i_idx] <= newc_ff;
                  count_ff <= count_ff + CW'(1);
                  state_ff <= S_DONE;
               end
            end
            S_MIX: begin
               dreq_ff.dividend <= num;
               dreq_ff.divisor  <= dsum[15:0];
               state_ff <= S_MIXW;
            end
            S_MIXW: begin
               if (drsp.done) begin
                  res_ff <= {res_ff[15:0], drsp.quotient[7:0]};
                  if (ch_ff == 2'd2) state_ff <= S_DONE;
                  else begin
                     ch_ff <= ch_ff + 2'd1; state_ff <= S_MIX;
                  end
               end
            end
            S_SCAN: begin
               // scale one stop through the divider
               if (i_ff == count_ff) begin
                  count_ff <= n_ff; state_ff <= S_DONE;
               end else begin
                  dreq_ff.dividend <= {8'd0, mul_s} + {25'd0, span_ff[15:1]};
                  dreq_ff.divisor  <= span_ff;
                  state_ff <= S_SCW;
               end
            end
            S_SCW: begin
               if (drsp.done) begin
                  logic [15:0] q;
                  q = (drsp.quotient > 40'hFFFF) ? 16'hFFFF : drsp.quotient[15:0];
                  if (drsp.quotient > 40'hFFFF) st_ff <= cgst_pkg::ST_CLAMP;
                  if (n_ff != '0 && lastq_ff == q)
                     col_mem[IW'(n_ff - CW'(1))] <= col_i;
                  else begin
                     pos_mem[n_idx] <= q;
                     col_mem[n_idx] <= col_i;
                     n_ff <= n_ff + CW'(1);
                  end
                  lastq_ff <= q;
                  i_ff <= i_ff + CW'(1);
                  state_ff <= S_SCAN;
               end
            end
            S_DONE: begin
               rsp_mixed_red   <= res_ff[23:16];
               rsp_mixed_green <= res_ff[15:8];
               rsp_mixed_blue  <= res_ff[7:0];
               rsp_status      <= st_ff;
               rsp_left_bound  <= (count_ff == '0) ? 16'd0 : pos_mem[0];
               rsp_right_bound <= (count_ff == '0) ? 16'd0 : pos_mem[last_idx];
               state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign busy = (state_ff != S_IDLE);

   a_count_max: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(cgst_pkg::MaxStops)) else $error("stop count overflow");
   a_rsp_after_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(state_ff == S_DONE)) else $error("stray result");
   a_count_only_up_one: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_SHIFT && !(n_ff > i_ff) |=> count_ff == $past(count_ff) + CW'(1))
      else $error("insert count");
endmodule
`default_nettype wire
